FILE: src/sparse_disk_block_map_assert.svh
// Assertion macros shared by the sparse disk block map RTL.
`ifndef SPARSE_DISK_BLOCK_MAP_ASSERT_SVH
`define SPARSE_DISK_BLOCK_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SDBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse disk block map: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define SDBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse disk block map: next-cycle check failed");

`endif

FILE: src/sdbm_pkg.sv
// Shared constants and codes of the sparse disk block map.
package sdbm_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int LBA_W    = 32;
  localparam int EIDX_W   = 12;
  localparam int EVAL_W   = 32;
  localparam int STATUS_W = 3;
  localparam int FSEC_W   = 33;
  localparam int BIDX_W   = 12;
  localparam int NEWE_W   = 32;
  localparam int SPB_W    = 24;
  localparam int CNT_W    = 13;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_START_SECTOR = 2'd2;
  localparam logic [SPB_W-1:0]     SPB_RESET             = 24'd4096;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_MAPPED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNALLOC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Table entry that marks a block with no storage yet.
  localparam logic [EVAL_W-1:0] UNALLOCATED = 32'hFFFF_FFFF;

  // Divider: one quotient bit per step.
  localparam int DIV_STEPS = LBA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

endpackage

FILE: src/sdbm_ifs.sv
// Request and response channel interfaces of the sparse disk block map.
interface sdbm_req_if;
  logic                            valid;
  logic                            ready;
  logic [sdbm_pkg::KIND_W-1:0]     kind;
  logic [sdbm_pkg::LBA_W-1:0]      lba;
  logic [sdbm_pkg::EIDX_W-1:0]     entry_index;
  logic [sdbm_pkg::EVAL_W-1:0]     entry_value;

  modport source (output valid, kind, lba, entry_index, entry_value, input ready);
  modport sink   (input valid, kind, lba, entry_index, entry_value, output ready);
endinterface

interface sdbm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sdbm_pkg::STATUS_W-1:0]   status;
  logic [sdbm_pkg::FSEC_W-1:0]     file_sector;
  logic [sdbm_pkg::BIDX_W-1:0]     block_index;
  logic [sdbm_pkg::NEWE_W-1:0]     new_entry;

  modport source (output valid, status, file_sector, block_index, new_entry, input ready);
  modport sink   (input valid, status, file_sector, block_index, new_entry, output ready);
endinterface

FILE: src/sdbm_ram.sv
// Generic single-port RAM with registered read data.
module sdbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read of the addressed entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/sparse_disk_block_map.sv
// Top level of the sparse disk block map: sequencer, divider and table.

// The block maps a guest sector to its sector in a sparse disk image through a
// 4096-entry block allocation table held in a single-port RAM. It works on one
// beat at a time: req.ready is high only while idle, and a result beat waits
// in an output register until rsp takes it. A table load goes from the accept
// straight to the output register. A lookup runs a restoring divider that forms
// one quotient bit per cycle for lba / sectors_per_block, then a range check
// state that also issues the table read, then a state that evaluates the entry
// and, for a write lookup, allocates the block, and then the output register.
// An out of range lookup skips the evaluation state. With a zero block size a
// lookup goes straight to the output register and answers out of range. A
// stalled result beat holds the output register, and the next request is
// accepted from the cycle after the result beat is taken. The table is not
// cleared at reset and must be loaded before it is looked up.
module sparse_disk_block_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sdbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  sdbm_req_if.sink                          req,
  sdbm_rsp_if.source                        rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_CHK  = 5'b00100,
    S_ENT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration and pointer state.
  logic [sdbm_pkg::SPB_W-1:0]    sectors_per_block;
  logic [sdbm_pkg::CNT_W-1:0]    entry_count;
  logic [sdbm_pkg::LBA_W-1:0]    next_free_sector;

  // Working registers of the current item.
  logic [sdbm_pkg::KIND_W-1:0]   kind_q;
  logic [sdbm_pkg::LBA_W-1:0]    quo;
  logic [sdbm_pkg::SPB_W-1:0]    rem;
  logic [sdbm_pkg::STEP_W-1:0]   step;

  // Result registers.
  logic [sdbm_pkg::STATUS_W-1:0] status_q;
  logic [sdbm_pkg::FSEC_W-1:0]   fsec_q;
  logic [sdbm_pkg::BIDX_W-1:0]   bidx_q;
  logic [sdbm_pkg::NEWE_W-1:0]   newe_q;

  // Table RAM port.
  logic                          ram_we;
  logic [sdbm_pkg::ADDR_W-1:0]   ram_addr;
  logic [sdbm_pkg::EVAL_W-1:0]   ram_wdata;
  logic [sdbm_pkg::EVAL_W-1:0]   ram_rdata;

  logic                          req_fire;
  logic                          load_fire;
  logic [sdbm_pkg::SPB_W:0]      div_trial;
  logic                          div_ge;
  logic [sdbm_pkg::SPB_W:0]      div_diff;
  logic [sdbm_pkg::CNT_W-1:0]    count_eff;
  logic                          out_of_range;
  logic [sdbm_pkg::ADDR_W-1:0]   bidx;
  logic                          entry_unalloc;
  logic [sdbm_pkg::LBA_W:0]      advanced;
  logic                          alloc_ok;
  logic                          alloc_fire;
  logic [sdbm_pkg::EVAL_W-1:0]   base;
  logic [sdbm_pkg::FSEC_W-1:0]   fsec_sum;

  // Handshake.
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign load_fire = req_fire && (req.kind == sdbm_pkg::KIND_LOAD)
                     && (32'(req.entry_index) < 32'(sdbm_pkg::TABLE_DEPTH));

  assign rsp.valid       = (state == S_OUT);
  assign rsp.status      = status_q;
  assign rsp.file_sector = fsec_q;
  assign rsp.block_index = bidx_q;
  assign rsp.new_entry   = newe_q;

  // One restoring divider step: shift in the next dividend bit, try a subtract.
  assign div_trial = {rem, quo[sdbm_pkg::LBA_W-1]};
  assign div_ge    = (div_trial >= {1'b0, sectors_per_block});
  assign div_diff  = div_trial - {1'b0, sectors_per_block};

  // Range check of the block index against the effective entry count.
  assign count_eff = (entry_count > sdbm_pkg::CNT_W'(sdbm_pkg::TABLE_DEPTH))
                     ? sdbm_pkg::CNT_W'(sdbm_pkg::TABLE_DEPTH) : entry_count;
  assign out_of_range = (quo >= 32'(count_eff));
  assign bidx         = quo[sdbm_pkg::ADDR_W-1:0];

  // Entry evaluation and allocation.
  assign entry_unalloc = (ram_rdata == sdbm_pkg::UNALLOCATED);
  assign advanced      = {1'b0, next_free_sector} + 33'(sectors_per_block) + 33'd1;
  assign alloc_ok      = entry_unalloc && (kind_q == sdbm_pkg::KIND_WRITE)
                         && !advanced[sdbm_pkg::LBA_W];
  assign alloc_fire    = (state == S_ENT) && alloc_ok;
  assign base          = entry_unalloc ? next_free_sector : ram_rdata;
  assign fsec_sum      = {1'b0, base} + 33'(rem) + 33'd1;

  // The table port is written by loads while idle and by allocations.
  assign ram_we    = load_fire || alloc_fire;
  assign ram_addr  = (state == S_IDLE) ? req.entry_index[sdbm_pkg::ADDR_W-1:0] : bidx;
  assign ram_wdata = (state == S_IDLE) ? req.entry_value : next_free_sector;

  sdbm_ram #(
    .WIDTH (sdbm_pkg::EVAL_W),
    .DEPTH (sdbm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.kind == sdbm_pkg::KIND_LOAD || sectors_per_block == '0) begin
            state_next = S_OUT;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (step == sdbm_pkg::STEP_W'(sdbm_pkg::DIV_STEPS - 1)) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = out_of_range ? S_OUT : S_ENT;
      end
      S_ENT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state, configuration registers and the free pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sectors_per_block <= sdbm_pkg::SPB_RESET;
      entry_count       <= '0;
      next_free_sector  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        priority if (cfg_index == sdbm_pkg::REG_SECTORS_PER_BLOCK) begin
          sectors_per_block <= cfg_data[sdbm_pkg::SPB_W-1:0];
        end else if (cfg_index == sdbm_pkg::REG_ENTRY_COUNT) begin
          entry_count <= cfg_data[sdbm_pkg::CNT_W-1:0];
        end else if (cfg_index == sdbm_pkg::REG_FREE_START_SECTOR) begin
          next_free_sector <= cfg_data[sdbm_pkg::LBA_W-1:0];
        end
      end
      if (alloc_fire) begin
        next_free_sector <= advanced[sdbm_pkg::LBA_W-1:0];
      end
    end
  end

  // Datapath: divider iterations and result capture.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          kind_q <= req.kind;
          quo    <= req.lba;
          rem    <= '0;
          step   <= '0;
          if (req.kind == sdbm_pkg::KIND_LOAD) begin
            status_q <= sdbm_pkg::ST_MAPPED;
            fsec_q   <= '0;
            bidx_q   <= req.entry_index;
            newe_q   <= '0;
          end else begin
            status_q <= sdbm_pkg::ST_RANGE;
            fsec_q   <= '0;
            bidx_q   <= '0;
            newe_q   <= '0;
          end
        end
      end
      S_DIV: begin
        quo  <= {quo[sdbm_pkg::LBA_W-2:0], div_ge};
        rem  <= div_ge ? div_diff[sdbm_pkg::SPB_W-1:0] : div_trial[sdbm_pkg::SPB_W-1:0];
        step <= step + 1'b1;
      end
      S_CHK: begin
        // Out of range keeps the status and zero fields set at accept.
      end
      S_ENT: begin
        bidx_q <= sdbm_pkg::BIDX_W'(bidx);
        priority if (!entry_unalloc) begin
          status_q <= sdbm_pkg::ST_MAPPED;
          fsec_q   <= fsec_sum;
        end else if (kind_q != sdbm_pkg::KIND_WRITE) begin
          status_q <= sdbm_pkg::ST_UNALLOC;
        end else if (advanced[sdbm_pkg::LBA_W]) begin
          status_q <= sdbm_pkg::ST_FULL;
        end else begin
          status_q <= sdbm_pkg::ST_NEW;
          fsec_q   <= fsec_sum;
          newe_q   <= next_free_sector;
        end
      end
      S_OUT: begin
        // Hold the result beat until it is taken.
      end
      default: begin
      end
    endcase
  end

  `include "sparse_disk_block_map_assert.svh"

  // A result beat never overlaps an accepting request channel.
  `SDBM_ASSERT_NOW(a_one_item, rsp.valid, !req.ready)
  // An allocation advances the free pointer by one block plus its bitmap sector.
  `SDBM_ASSERT_NEXT(a_ptr_advance, alloc_fire,
                    next_free_sector == $past(advanced[31:0]))
  // A newly allocated block places data after its bitmap sector.
  `SDBM_ASSERT_NOW(a_new_place, rsp.valid && rsp.status == sdbm_pkg::ST_NEW,
                   rsp.file_sector > {1'b0, rsp.new_entry})
  // The divider finishes exactly when the range check begins.
  `SDBM_ASSERT_NEXT(a_div_done,
                    state == S_DIV && step == sdbm_pkg::STEP_W'(sdbm_pkg::DIV_STEPS - 1),
                    state == S_CHK)

endmodule
